// ===== rtl/core/pgwalk_pkg.sv =====
// ----------------------------------------------------------------------------
// pgwalk_pkg
// Shared types, codes and helpers of the four-level page table walker.
// ----------------------------------------------------------------------------
package pgwalk_pkg;

	// Field widths
	localparam int VA_W     = 48;
	localparam int PAGE_W   = 40;
	localparam int FLAGS_W  = 12;
	localparam int PA_W     = 52;
	localparam int ENTRY_W  = 64;
	localparam int IDX_W    = 9;
	localparam int OFF_W    = 12;
	localparam int LEVEL_W  = 2;
	localparam int STATUS_W = 2;

	// Configuration port
	localparam int APB_AW = 4;
	localparam int APB_DW = 64;
	localparam logic REG_POOL_BASE = 1'b0;

	// Request codes
	localparam logic REQ_MAP   = 1'b0;
	localparam logic REQ_XLATE = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOFRAME  = 2'd2;

	// Walk levels
	localparam logic [LEVEL_W-1:0] LEVEL_ROOT = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_PDPT = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_DIR  = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

	// present | writable | user for table entries
	localparam logic [OFF_W-1:0] TABLE_ENTRY_BITS = 12'h007;

	typedef enum logic [2:0] {
		WS_IDLE,
		WS_READ,
		WS_CHECK,
		WS_LEAF,
		WS_DONE
	} walk_state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

	// 9-bit table index of a virtual address at a given level
	function automatic logic [IDX_W-1:0] idx_of(input logic [VA_W-1:0] va,
	                                             input logic [LEVEL_W-1:0] lvl);
		logic [IDX_W-1:0] idx;
		unique case (lvl)
			LEVEL_ROOT: idx = va[47:39];
			LEVEL_PDPT: idx = va[38:30];
			LEVEL_DIR:  idx = va[29:21];
			default:    idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

// ===== rtl/core/pgwalk_cfg.sv =====
// ----------------------------------------------------------------------------
// pgwalk_cfg
// APB register slice holding the pool base page number.
// ----------------------------------------------------------------------------
module pgwalk_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [pgwalk_pkg::APB_AW-1:0]         paddr,
	input  logic [pgwalk_pkg::APB_DW-1:0]         pwdata,
	output logic [pgwalk_pkg::APB_DW-1:0]         prdata,
	output logic                                  pready,
	output logic [pgwalk_pkg::PAGE_W-1:0]         pool_base_page
);

	logic                              reg_sel;
	logic                              wr_en;
	logic [pgwalk_pkg::PAGE_W-1:0]     pool_base_q;

	assign pready  = 1'b1;
	// 8-byte register slots: bit 3 picks the register
	assign reg_sel = paddr[pgwalk_pkg::APB_AW-1];
	assign wr_en   = psel && penable && pwrite && pready
	                 && (reg_sel == pgwalk_pkg::REG_POOL_BASE);

	// Register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
		end else if (wr_en) begin
			pool_base_q <= pwdata[pgwalk_pkg::PAGE_W-1:0];
		end
	end

	// Read back
	always_comb begin
		unique case (reg_sel)
			pgwalk_pkg::REG_POOL_BASE: begin
				prdata = {{(pgwalk_pkg::APB_DW - pgwalk_pkg::PAGE_W){1'b0}}, pool_base_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign pool_base_page = pool_base_q;

endmodule

// ===== rtl/core/pgwalk_store.sv =====
// ----------------------------------------------------------------------------
// pgwalk_store
// Table frame memory with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module pgwalk_store #(
	parameter int TABLE_FRAMES = 64,
	parameter int AW           = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pgwalk_pkg::mem_cmd_t                cmd,
	input  logic [AW-1:0]                       addr,
	input  logic [pgwalk_pkg::ENTRY_W-1:0]      wdata,
	output logic [pgwalk_pkg::ENTRY_W-1:0]      rdata,
	output logic                                busy
);

	localparam int DEPTH = TABLE_FRAMES * 512;

	logic [pgwalk_pkg::ENTRY_W-1:0] mem [DEPTH];
	logic [pgwalk_pkg::ENTRY_W-1:0] rdata_q;
	logic [AW-1:0]                  clr_addr_q;
	logic                           clr_busy_q;
	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic [pgwalk_pkg::ENTRY_W-1:0] wr_data;

	// Clear sweep owns the write port until done
	always_comb begin
		wr_en   = clr_busy_q || cmd.wr;
		wr_addr = clr_busy_q ? clr_addr_q : addr;
		wr_data = clr_busy_q ? '0 : wdata;
	end

	// Clear sweep counter, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Memory array: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

// ===== rtl/core/pgwalk_seq.sv =====
// ----------------------------------------------------------------------------
// pgwalk_seq
// Walk sequencer: reads one level at a time, a read state then a check state,
// allocates frames, writes the leaf and holds the result in an output register.
// ----------------------------------------------------------------------------
module pgwalk_seq #(
	parameter int TABLE_FRAMES = 64,
	parameter int FW           = 6,
	parameter int NW           = 7,
	parameter int AW           = 15
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic [pgwalk_pkg::VA_W-1:0]          virt_addr,
	input  logic [pgwalk_pkg::PAGE_W-1:0]        phys_page,
	input  logic [pgwalk_pkg::FLAGS_W-1:0]       leaf_flags,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pgwalk_pkg::PA_W-1:0]          phys_addr,
	output logic [pgwalk_pkg::STATUS_W-1:0]      status,
	// config
	input  logic [pgwalk_pkg::PAGE_W-1:0]        pool_base_page,
	// table store
	output pgwalk_pkg::mem_cmd_t                 mem_cmd,
	output logic [AW-1:0]                        mem_addr,
	output logic [pgwalk_pkg::ENTRY_W-1:0]       mem_wdata,
	input  logic [pgwalk_pkg::ENTRY_W-1:0]       mem_rdata,
	input  logic                                 store_busy
);

	pgwalk_pkg::walk_state_t state_q, state_d;

	logic [pgwalk_pkg::LEVEL_W-1:0]   lvl_q;
	logic [FW-1:0]                    frame_q;
	logic [NW-1:0]                    nf_q;
	logic                             req_q;
	logic [pgwalk_pkg::VA_W-1:0]      va_q;
	logic [pgwalk_pkg::PAGE_W-1:0]    page_q;
	logic [pgwalk_pkg::FLAGS_W-1:0]   flags_q;
	logic [pgwalk_pkg::PA_W-1:0]      res_addr_q;
	logic [pgwalk_pkg::STATUS_W-1:0]  res_status_q;
	logic                             out_valid_q;
	logic [pgwalk_pkg::PA_W-1:0]      out_addr_q;
	logic [pgwalk_pkg::STATUS_W-1:0]  out_status_q;

	logic                             in_accept;
	logic                             res_load;
	logic [pgwalk_pkg::IDX_W-1:0]     lvl_idx;
	logic [pgwalk_pkg::PAGE_W-1:0]    ent_rel;
	logic                             ent_in_pool;
	logic                             pool_full;
	logic [pgwalk_pkg::PAGE_W-1:0]    alloc_page;
	logic                             chk_alloc;
	logic                             chk_advance;
	logic                             chk_done;
	logic [pgwalk_pkg::STATUS_W-1:0]  chk_status;
	logic [pgwalk_pkg::PA_W-1:0]      chk_addr;
	logic [FW-1:0]                    frame_next;

	assign in_accept = in_valid && !in_stall;

	// Entry check: decode the entry just read
	always_comb begin
		ent_rel     = mem_rdata[51:12] - pool_base_page;
		ent_in_pool = ent_rel < pgwalk_pkg::PAGE_W'(TABLE_FRAMES);
		pool_full   = nf_q >= NW'(TABLE_FRAMES);
		alloc_page  = pool_base_page + pgwalk_pkg::PAGE_W'(nf_q);
		chk_alloc   = 1'b0;
		chk_advance = 1'b0;
		chk_done    = 1'b0;
		chk_status  = pgwalk_pkg::ST_OK;
		chk_addr    = '0;
		if (req_q == pgwalk_pkg::REQ_XLATE) begin
			if (lvl_q == pgwalk_pkg::LEVEL_LEAF) begin
				chk_done = 1'b1;
				if (mem_rdata[0]) begin
					chk_addr = {mem_rdata[51:12], va_q[pgwalk_pkg::OFF_W-1:0]};
				end else begin
					chk_status = pgwalk_pkg::ST_UNMAPPED;
				end
			end else if (mem_rdata[0] && ent_in_pool) begin
				chk_advance = 1'b1;
			end else begin
				chk_done   = 1'b1;
				chk_status = pgwalk_pkg::ST_UNMAPPED;
			end
		end else begin
			if (mem_rdata[0]) begin
				if (ent_in_pool) begin
					chk_advance = 1'b1;
				end else begin
					chk_done   = 1'b1;
					chk_status = pgwalk_pkg::ST_UNMAPPED;
				end
			end else if (pool_full) begin
				chk_done   = 1'b1;
				chk_status = pgwalk_pkg::ST_NOFRAME;
			end else begin
				chk_alloc   = 1'b1;
				chk_advance = 1'b1;
			end
		end
		frame_next = chk_alloc ? nf_q[FW-1:0] : ent_rel[FW-1:0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pgwalk_pkg::WS_IDLE: begin
				if (in_accept) begin
					state_d = pgwalk_pkg::WS_READ;
				end
			end
			pgwalk_pkg::WS_READ: begin
				state_d = pgwalk_pkg::WS_CHECK;
			end
			pgwalk_pkg::WS_CHECK: begin
				if (chk_done) begin
					state_d = pgwalk_pkg::WS_DONE;
				end else if (req_q == pgwalk_pkg::REQ_MAP
				             && lvl_q == pgwalk_pkg::LEVEL_DIR) begin
					state_d = pgwalk_pkg::WS_LEAF;
				end else begin
					state_d = pgwalk_pkg::WS_READ;
				end
			end
			pgwalk_pkg::WS_LEAF: begin
				state_d = pgwalk_pkg::WS_DONE;
			end
			pgwalk_pkg::WS_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = pgwalk_pkg::WS_IDLE;
				end
			end
			default: begin
				state_d = pgwalk_pkg::WS_IDLE;
			end
		endcase
	end

	// Outputs of the state machine
	always_comb begin
		in_stall   = (state_q != pgwalk_pkg::WS_IDLE) || store_busy;
		lvl_idx    = pgwalk_pkg::idx_of(va_q, lvl_q);
		mem_cmd.rd = (state_q == pgwalk_pkg::WS_READ);
		mem_cmd.wr = ((state_q == pgwalk_pkg::WS_CHECK) && chk_alloc)
		             || (state_q == pgwalk_pkg::WS_LEAF);
		mem_addr   = {frame_q, lvl_idx};
		if (state_q == pgwalk_pkg::WS_LEAF) begin
			mem_wdata = {{(pgwalk_pkg::ENTRY_W - pgwalk_pkg::PAGE_W - pgwalk_pkg::FLAGS_W){1'b0}},
			             page_q, flags_q};
		end else begin
			mem_wdata = {{(pgwalk_pkg::ENTRY_W - pgwalk_pkg::PAGE_W - pgwalk_pkg::OFF_W){1'b0}},
			             alloc_page, pgwalk_pkg::TABLE_ENTRY_BITS};
		end
		res_load = (state_q == pgwalk_pkg::WS_DONE) && (!out_valid_q || !out_stall);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pgwalk_pkg::WS_IDLE;
			lvl_q       <= pgwalk_pkg::LEVEL_ROOT;
			frame_q     <= '0;
			nf_q        <= NW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				lvl_q   <= pgwalk_pkg::LEVEL_ROOT;
				frame_q <= '0;
			end
			if (state_q == pgwalk_pkg::WS_CHECK) begin
				if (chk_advance) begin
					lvl_q   <= lvl_q + 2'd1;
					frame_q <= frame_next;
				end
				if (chk_alloc) begin
					nf_q <= nf_q + 1'b1;
				end
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q        <= req_type;
			va_q         <= virt_addr;
			page_q       <= phys_page;
			flags_q      <= leaf_flags;
			res_addr_q   <= '0;
			res_status_q <= pgwalk_pkg::ST_OK;
		end else if ((state_q == pgwalk_pkg::WS_CHECK) && chk_done) begin
			res_addr_q   <= chk_addr;
			res_status_q <= chk_status;
		end
		if (res_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign phys_addr = out_addr_q;
	assign status    = out_status_q;

	// Checks
	a_nf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= NW'(TABLE_FRAMES))
		else $error("free frame counter past pool size");

	a_frame_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(frame_q) < TABLE_FRAMES)
		else $error("walk frame outside pool");

	a_nf_write: assert property (@(posedge clk) disable iff (!arst_n)
		(nf_q != $past(nf_q)) |-> $past(mem_cmd.wr))
		else $error("frame allocated without a table entry write");

	a_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_cmd.rd && mem_cmd.wr))
		else $error("read and write issued together");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == pgwalk_pkg::WS_DONE))
		else $error("result raised outside done state");

endmodule

// ===== rtl/core/four_level_page_table_walker_unit.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit
// Four-level page table walker over a private pool of table frames.
//
// Items are handled one at a time. A translate reads all four levels, fewer
// when it meets an absent or foreign entry on the way. A map reads at most
// three levels and then writes the leaf, fewer when it stops on a foreign
// entry or an empty pool. The next item can be taken in the same cycle that
// the result appears. The pace is set by the single table memory: each level
// takes a read state and a check state because the read data comes back
// registered, and table allocations and the leaf store share its write port.
// After reset the table memory is swept to zero one entry a cycle, all
// TABLE_FRAMES * 512 entries (32768 at the default), and no item is accepted
// until the sweep is done; the register port works throughout. A result can
// wait in the output register while the next item is taken; that next result
// then holds the walker until the waiting one is taken.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit #(
	parameter int TABLE_FRAMES = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic [pgwalk_pkg::VA_W-1:0]          virt_addr,
	input  logic [pgwalk_pkg::PAGE_W-1:0]        phys_page,
	input  logic [pgwalk_pkg::FLAGS_W-1:0]       leaf_flags,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pgwalk_pkg::PA_W-1:0]          phys_addr,
	output logic [pgwalk_pkg::STATUS_W-1:0]      status,
	// register port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pgwalk_pkg::APB_AW-1:0]        paddr,
	input  logic [pgwalk_pkg::APB_DW-1:0]        pwdata,
	output logic [pgwalk_pkg::APB_DW-1:0]        prdata,
	output logic                                 pready
);

	localparam int FW = $clog2(TABLE_FRAMES);
	localparam int NW = $clog2(TABLE_FRAMES + 1);
	localparam int AW = FW + pgwalk_pkg::IDX_W;

	logic [pgwalk_pkg::PAGE_W-1:0]   pool_base_page;
	pgwalk_pkg::mem_cmd_t            mem_cmd;
	logic [AW-1:0]                   mem_addr;
	logic [pgwalk_pkg::ENTRY_W-1:0]  mem_wdata;
	logic [pgwalk_pkg::ENTRY_W-1:0]  mem_rdata;
	logic                            store_busy;

	// Register slice
	pgwalk_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.pool_base_page (pool_base_page)
	);

	// Table frame memory
	pgwalk_store #(
		.TABLE_FRAMES (TABLE_FRAMES),
		.AW           (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mem_cmd),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata),
		.busy   (store_busy)
	);

	// Walk sequencer
	pgwalk_seq #(
		.TABLE_FRAMES (TABLE_FRAMES),
		.FW           (FW),
		.NW           (NW),
		.AW           (AW)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.virt_addr      (virt_addr),
		.phys_page      (phys_page),
		.leaf_flags     (leaf_flags),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.phys_addr      (phys_addr),
		.status         (status),
		.pool_base_page (pool_base_page),
		.mem_cmd        (mem_cmd),
		.mem_addr       (mem_addr),
		.mem_wdata      (mem_wdata),
		.mem_rdata      (mem_rdata),
		.store_busy     (store_busy)
	);

endmodule
